// File: rtl/core/gfq_pkg.sv
// Shared types and constants for the GF(2^M) quadratic root finder.
package gfq_pkg;

   localparam int FIELD_BITS_DEFAULT = 8;
   localparam int POLY_BITS          = 9;
   localparam int C_BITS             = 8;
   localparam int LOG_BITS           = 8;
   localparam int COUNT_BITS         = 2;

   localparam logic [POLY_BITS-1:0]  PRIM_POLY_RESET = 9'd285;
   localparam logic [COUNT_BITS-1:0] ROOT_COUNT_NONE = 2'd0;
   localparam logic [COUNT_BITS-1:0] ROOT_COUNT_ONE  = 2'd1;
   localparam logic [COUNT_BITS-1:0] ROOT_COUNT_TWO  = 2'd2;

   typedef enum logic [1:0] {
      GFQ_IDLE,
      GFQ_WALK,
      GFQ_DONE
   } gfq_state_type;

   // sequencer commands to the power walker
   typedef struct packed {
      logic load;      // restart at alpha^0
      logic advance;   // step to the next power
   } gfq_walk_ctl_type;

endpackage

// File: rtl/core/gfq_mul_alpha.sv
// Multiply a field element by alpha: one LFSR step modulo the field polynomial.
module gfq_mul_alpha #(
   parameter int FIELD_BITS = gfq_pkg::FIELD_BITS_DEFAULT
) (
   input  logic [FIELD_BITS-1:0] poly_low,
   input  logic [FIELD_BITS-1:0] elem,
   output logic [FIELD_BITS-1:0] product
);
   import gfq_pkg::*;

   logic [FIELD_BITS-1:0] shifted;

   assign shifted = {elem[FIELD_BITS-2:0], 1'b0};
   assign product = elem[FIELD_BITS-1] ? (shifted ^ poly_low) : shifted;

endmodule

// File: rtl/core/gfq_walker.sv
// Power walker: steps x = alpha^i and x^2 = alpha^(2i) together with the index i.
module gfq_walker #(
   parameter int FIELD_BITS = gfq_pkg::FIELD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gfq_pkg::gfq_walk_ctl_type ctl,
   input  logic [FIELD_BITS-1:0]    poly_low,
   output logic [FIELD_BITS-1:0]    x_value,
   output logic [FIELD_BITS-1:0]    x_next,
   output logic [FIELD_BITS-1:0]    sq_value,
   output logic [FIELD_BITS-1:0]    index,
   output logic                     is_last
);
   import gfq_pkg::*;

   // last exponent of the walk is 2^M - 2
   localparam logic [FIELD_BITS-1:0] LAST_INDEX = FIELD_BITS'((1 << FIELD_BITS) - 2);
   localparam logic [FIELD_BITS-1:0] ONE        = FIELD_BITS'(1);

   logic [FIELD_BITS-1:0] x_ff, x_in;
   logic [FIELD_BITS-1:0] sq_ff, sq_in;
   logic [FIELD_BITS-1:0] index_ff, index_in;
   logic [FIELD_BITS-1:0] sq_half;
   logic [FIELD_BITS-1:0] sq_next;

   gfq_mul_alpha #(.FIELD_BITS(FIELD_BITS)) u_mul_x (
      .poly_low (poly_low),
      .elem     (x_ff),
      .product  (x_next)
   );

   // square advances by alpha^2 per step
   gfq_mul_alpha #(.FIELD_BITS(FIELD_BITS)) u_mul_sq_a (
      .poly_low (poly_low),
      .elem     (sq_ff),
      .product  (sq_half)
   );

   gfq_mul_alpha #(.FIELD_BITS(FIELD_BITS)) u_mul_sq_b (
      .poly_low (poly_low),
      .elem     (sq_half),
      .product  (sq_next)
   );

   always_comb begin
      x_in     = x_ff;
      sq_in    = sq_ff;
      index_in = index_ff;
      if (ctl.load) begin
         x_in     = ONE;
         sq_in    = ONE;
         index_in = '0;
      end else if (ctl.advance) begin
         x_in     = x_next;
         sq_in    = sq_next;
         index_in = index_ff + ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= ONE;
         sq_ff    <= ONE;
         index_ff <= '0;
      end else begin
         x_ff     <= x_in;
         sq_ff    <= sq_in;
         index_ff <= index_in;
      end
   end

   assign x_value  = x_ff;
   assign sq_value = sq_ff;
   assign index    = index_ff;
   assign is_last  = (index_ff == LAST_INDEX);

endmodule

// File: rtl/core/gf_quadratic_root_finder.sv
// Top level of the GF(2^M) quadratic root finder: sequencer, match logic, result registers.
//
// Solves x^2 + x + c = 0 over GF(2^M) defined by csr_write_data (primitive polynomial
// including the x^M term, reset value 0x11D). A transaction is taken when start is high
// and busy is low; the result appears for exactly one cycle with rsp_strobe and cannot
// be stalled. A transaction walks alpha^i one power per cycle through LFSR step units,
// then gives a result cycle, during which the next transaction may already start.
// A polynomial of wrong degree is answered in the cycle after start; a non-primitive
// one as soon as the walk returns to 1.
// Roots are given as exponents, smaller first; c = 0 reports no roots.
module gf_quadratic_root_finder #(
   parameter int FIELD_BITS = gfq_pkg::FIELD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [gfq_pkg::C_BITS-1:0]         req_c_value,
   input  logic                               csr_write_enable,
   input  logic [gfq_pkg::POLY_BITS-1:0]      csr_write_data,
   output logic                               rsp_strobe,
   output logic [gfq_pkg::COUNT_BITS-1:0]     rsp_root_count,
   output logic [gfq_pkg::LOG_BITS-1:0]       rsp_root_first_log,
   output logic [gfq_pkg::LOG_BITS-1:0]       rsp_root_second_log,
   output logic                               rsp_poly_error
);
   import gfq_pkg::*;

   localparam int PW = (FIELD_BITS + 1 > POLY_BITS) ? FIELD_BITS + 1 : POLY_BITS;
   localparam int CW = (FIELD_BITS > C_BITS) ? FIELD_BITS : C_BITS;
   localparam logic [FIELD_BITS-1:0] ONE = FIELD_BITS'(1);

   gfq_state_type    state_ff, state_in;
   gfq_walk_ctl_type walk_ctl;

   logic [POLY_BITS-1:0]  prim_poly_ff, prim_poly_in;
   logic [C_BITS-1:0]     c_ff, c_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [LOG_BITS-1:0]   first_log_ff, first_log_in;
   logic [LOG_BITS-1:0]   second_log_ff, second_log_in;
   logic                  err_ff, err_in;

   logic [PW-1:0]         poly_ext;
   logic [FIELD_BITS-1:0] poly_low;
   logic                  degree_ok;
   logic                  accept;
   logic [FIELD_BITS-1:0] x_value, x_next, sq_value, walk_index;
   logic                  walk_last;
   logic                  match;
   logic [CW-1:0]         index_ext;

   // config register
   assign prim_poly_in = csr_write_enable ? csr_write_data : prim_poly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prim_poly_ff <= PRIM_POLY_RESET;
      end else begin
         prim_poly_ff <= prim_poly_in;
      end
   end

   assign poly_ext  = PW'(prim_poly_ff);
   assign poly_low  = poly_ext[FIELD_BITS-1:0];
   // degree exactly M: bit M set, nothing above
   assign degree_ok = ((poly_ext >> FIELD_BITS) == PW'(1));

   gfq_walker #(.FIELD_BITS(FIELD_BITS)) u_walker (
      .clock    (clock),
      .reset    (reset),
      .ctl      (walk_ctl),
      .poly_low (poly_low),
      .x_value  (x_value),
      .x_next   (x_next),
      .sq_value (sq_value),
      .index    (walk_index),
      .is_last  (walk_last)
   );

   assign busy      = (state_ff == GFQ_WALK);
   assign accept    = start && !busy;
   assign match     = (c_ff != '0) && (CW'(c_ff) == CW'(sq_value ^ x_value));
   assign index_ext = CW'(walk_index);

   always_comb begin
      state_in      = state_ff;
      walk_ctl      = '0;
      c_in          = c_ff;
      count_in      = count_ff;
      first_log_in  = first_log_ff;
      second_log_in = second_log_ff;
      err_in        = err_ff;
      unique case (state_ff)
         GFQ_IDLE, GFQ_DONE: begin
            state_in = GFQ_IDLE;
            if (accept) begin
               c_in          = req_c_value;
               count_in      = ROOT_COUNT_NONE;
               first_log_in  = '0;
               second_log_in = '0;
               err_in        = !degree_ok;
               if (degree_ok) begin
                  walk_ctl.load = 1'b1;
                  state_in      = GFQ_WALK;
               end else begin
                  state_in = GFQ_DONE;
               end
            end
         end
         GFQ_WALK: begin
            if (walk_index != '0 && x_value == ONE) begin
               // order of alpha below 2^M - 1: not primitive
               err_in   = 1'b1;
               state_in = GFQ_DONE;
            end else begin
               walk_ctl.advance = 1'b1;
               if (match) begin
                  priority case (count_ff)
                     ROOT_COUNT_NONE: begin
                        first_log_in = index_ext[LOG_BITS-1:0];
                        count_in     = ROOT_COUNT_ONE;
                     end
                     ROOT_COUNT_ONE: begin
                        second_log_in = index_ext[LOG_BITS-1:0];
                        count_in      = ROOT_COUNT_TWO;
                     end
                     default: begin
                        count_in = count_ff;
                     end
                  endcase
               end
               if (walk_last) begin
                  if (x_next != ONE) begin
                     err_in = 1'b1;
                  end
                  state_in = GFQ_DONE;
               end
            end
         end
         default: begin
            state_in = GFQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GFQ_IDLE;
         count_ff <= ROOT_COUNT_NONE;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff          <= c_in;
      first_log_ff  <= first_log_in;
      second_log_ff <= second_log_in;
   end

   assign rsp_strobe          = (state_ff == GFQ_DONE);
   assign rsp_poly_error      = err_ff;
   assign rsp_root_count      = err_ff ? ROOT_COUNT_NONE : count_ff;
   assign rsp_root_first_log  = err_ff ? '0 : first_log_ff;
   assign rsp_root_second_log = err_ff ? '0 : second_log_ff;

   // wrong-degree polynomial is reported right after start
   a_degree_fast: assert property (@(posedge clock) disable iff (reset)
      (accept && !degree_ok) |=> (rsp_strobe && rsp_poly_error))
      else $error("wrong-degree polynomial not answered in next cycle");

   // roots come out in walk order
   a_root_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_root_count == ROOT_COUNT_TWO) |->
      (rsp_root_first_log < rsp_root_second_log))
      else $error("roots not in ascending exponent order");

   // in a valid field every equation reports zero or two roots
   a_root_pairs: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_poly_error) |->
      (rsp_root_count == ROOT_COUNT_NONE || rsp_root_count == ROOT_COUNT_TWO))
      else $error("odd root count in a primitive field");

   // the walker never runs while idle
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      walk_ctl.advance |-> busy)
      else $error("walker advanced outside a transaction");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for gf_quadratic_root_finder: random and directed equations.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gfq_pkg::*;

   localparam int M           = FIELD_BITS_DEFAULT;
   localparam int ORDER       = (1 << M) - 1;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_WAIT  = 260;

   typedef logic [POLY_BITS-1:0] poly_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [LOG_BITS-1:0]   first_log;
      logic [LOG_BITS-1:0]   second_log;
      logic                  poly_error;
   } roots_type;

   class root_scoreboard;
      poly_type  field_poly;
      roots_type expected_roots[$];
      int        mismatches;
      int        requests;
      int        two_root_results;
      int        error_results;

      function new();
         field_poly = PRIM_POLY_RESET;
      endfunction

      function void set_poly(poly_type p);
         field_poly = p;
      endfunction

      function int pending();
         return expected_roots.size();
      endfunction

      // x^2 reduced modulo the field polynomial
      function poly_type square_mod(poly_type x);
         poly_type acc;
         poly_type a;
         acc = '0;
         a   = x;
         for (int i = 0; i < M; i++) begin
            if (x[i]) acc ^= a;
            a = a << 1;
            if (a[M]) a ^= field_poly;
         end
         return acc;
      endfunction

      function roots_type solve_quadratic(logic [C_BITS-1:0] c);
         roots_type r;
         poly_type  x;
         int        deg;
         int        found;
         bit        bad;
         r     = '0;
         deg   = -1;
         found = 0;
         x     = poly_type'(1);
         for (int k = 0; k < POLY_BITS; k++)
            if (field_poly[k]) deg = k;
         bad = (deg != M);
         if (!bad) begin
            for (int i = 0; i < ORDER; i++) begin
               // early return to 1 means alpha is not primitive
               if (i != 0 && x == poly_type'(1)) begin
                  bad = 1;
                  break;
               end
               if (c != 0 && (square_mod(x) ^ x) == poly_type'(c)) begin
                  if (found == 0) r.first_log = i[LOG_BITS-1:0];
                  else if (found == 1) r.second_log = i[LOG_BITS-1:0];
                  if (found < 2) found++;
               end
               x = x << 1;
               if (x[M]) x ^= field_poly;
            end
            if (!bad && x != poly_type'(1)) bad = 1;
         end
         if (bad) begin
            r = '0;
            r.poly_error = 1'b1;
         end else begin
            r.count = found[COUNT_BITS-1:0];
         end
         return r;
      endfunction

      function void note_c(logic [C_BITS-1:0] c);
         expected_roots.push_back(solve_quadratic(c));
         requests++;
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("%0t ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_roots(roots_type got);
         roots_type want;
         if (expected_roots.size() == 0) begin
            report_mismatch("result with no transaction outstanding", 1, 0);
         end else begin
            want = expected_roots.pop_front();
            if (want.poly_error) error_results++;
            if (want.count == ROOT_COUNT_TWO) two_root_results++;
            if (got.count != want.count)
               report_mismatch("root_count", got.count, want.count);
            if (got.first_log != want.first_log)
               report_mismatch("root_first_log", got.first_log, want.first_log);
            if (got.second_log != want.second_log)
               report_mismatch("root_second_log", got.second_log, want.second_log);
            if (got.poly_error != want.poly_error)
               report_mismatch("poly_error", got.poly_error, want.poly_error);
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [C_BITS-1:0]  req_c_value = '0;
   logic               csr_write_enable = 1'b0;
   poly_type           csr_write_data = '0;
   logic               rsp_strobe;
   logic [COUNT_BITS-1:0] rsp_root_count;
   logic [LOG_BITS-1:0]   rsp_root_first_log;
   logic [LOG_BITS-1:0]   rsp_root_second_log;
   logic                  rsp_poly_error;

   root_scoreboard sb = new();
   int             idle_cycles = 0;
   int             poly_settings = 1;

   gf_quadratic_root_finder dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_c_value        (req_c_value),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_root_count     (rsp_root_count),
      .rsp_root_first_log (rsp_root_first_log),
      .rsp_root_second_log(rsp_root_second_log),
      .rsp_poly_error     (rsp_poly_error)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // monitor: notes accepted transactions, checks results, and runs the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_roots({rsp_root_count, rsp_root_first_log, rsp_root_second_log,
                            rsp_poly_error});
         if (start && !busy)
            sb.note_c(req_c_value);
         if (rsp_strobe || (start && !busy)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("gf_quadratic_root_finder: mismatch");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic int pick_gap(bit steady);
      int k;
      if (steady) return 0;
      k = $urandom_range(0, 99);
      if (k < 35) return 0;
      if (k < 65) return $urandom_range(1, 5);
      if (k < 85) return $urandom_range(6, 255);
      // land near the result cycle and just past it
      if (k < 95) return $urandom_range(250, 262);
      return $urandom_range(263, 320);
   endfunction

   function automatic logic [C_BITS-1:0] pick_c();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return 8'h01;
         2: return 8'hFF;
         3: return 8'h80;
         default: return C_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   // returns at the edge where the transaction is taken
   task automatic send_c(logic [C_BITS-1:0] c, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_c_value <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_poly(poly_type p);
      @(posedge clock);
      while (sb.pending() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= p;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_poly(p);
      poly_settings++;
   endtask

   task automatic run_phase(poly_type p, int items);
      bit steady;
      write_poly(p);
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < items; n++)
         send_c(pick_c(), pick_gap(steady));
      start <= 1'b0;
   endtask

   poly_type primitive_polys[16] = '{9'h11D, 9'h12B, 9'h12D, 9'h14D, 9'h15F, 9'h163,
                                     9'h165, 9'h169, 9'h171, 9'h187, 9'h18D, 9'h1A9,
                                     9'h1C3, 9'h1CF, 9'h1E7, 9'h1F5};
   logic [C_BITS-1:0] directed_c[18] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h08,
                                         8'h10, 8'h20, 8'h40, 8'h80, 8'hFF, 8'hFE,
                                         8'h7F, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h00};

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset polynomial, field extremes, back to back and spaced
      foreach (directed_c[i])
         send_c(directed_c[i], (i % 3 == 0) ? 0 : $urandom_range(1, 270));
      start <= 1'b0;

      run_phase(9'h000, 10);   // zero polynomial, wrong degree
      run_phase(9'h1FF, 15);
      run_phase(9'h100, 8);    // x^8 alone collapses to zero
      run_phase(9'h11B, 10);   // irreducible, not primitive
      run_phase(9'h0FF, 6);    // degree 7
      run_phase(9'h12B, 90);
      run_phase(9'h1F5, 90);
      run_phase(9'h165, 90);
      for (int k = 0; k < 3; k++)
         run_phase(poly_type'($urandom_range(0, 511)), 8);
      run_phase(primitive_polys[$urandom_range(0, 15)], 90);
      run_phase(PRIM_POLY_RESET, 90);

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d equations over %0d polynomial settings", sb.requests,
               poly_settings);
      $display("%0d answers had two roots, %0d flagged a bad polynomial",
               sb.two_root_results, sb.error_results);
      if (sb.mismatches == 0) begin
         $display("gf_quadratic_root_finder: match");
      end else begin
         $display("gf_quadratic_root_finder: mismatch");
      end
      $finish;
   end

endmodule
